>>> design/fwr_pkg.sv
// Package for the 2D full-weighting restriction block.
// Holds shared constants, register indexes, the window flag type and the size helper.
// No dependencies.
package fwr_pkg;

    // Default parameter values
    localparam int unsigned MAX_COARSE_DEF  = 512;
    localparam int unsigned SAMPLE_BITS_DEF = 16;

    // Fixed field widths
    localparam int unsigned CFG_W     = 10;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned OUT_W     = 20;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COARSE_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COARSE_COLS = 2'd1;

    // Taps in one 3x3 window
    localparam int unsigned NUM_TAPS = 9;

    // Classification of one window, carried with its taps
    typedef struct packed {
        logic row_odd;   // window centered one row back
        logic col_odd;   // window centered one column back
        logic last;      // final coarse value of the grid
    } t_wflags;

    // Last fine index for a coarse size, size saturated to [2, max_c]
    function automatic int unsigned fine_last(logic [CFG_W-1:0] v, int unsigned max_c);
        int unsigned s;
        s = int'(v);
        if (s < 2) begin
            s = 2;
        end else if (s > max_c) begin
            s = max_c;
        end
        return 2 * s - 2;
    endfunction

endpackage

>>> design/fwr_front.sv
// Front part of the restriction block: accepts fine samples, tracks the raster position,
// keeps the two-row line buffer and the window columns, and forwards complete windows.
// Depends on fwr_pkg.
module fwr_front #(
    parameter int unsigned MAX_COARSE  = fwr_pkg::MAX_COARSE_DEF,
    parameter int unsigned SAMPLE_BITS = fwr_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned QW          = $bits(fwr_pkg::t_wflags)
                                         + fwr_pkg::NUM_TAPS * SAMPLE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Sample channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]   i_fine_sample,
    // Configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fwr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fwr_pkg::CFG_W-1:0]       i_cfg_data,
    // Window queue push side
    output logic                            o_push,
    output logic [QW-1:0]                   o_push_data,
    input  logic                            i_q_full
);
    import fwr_pkg::*;

    localparam int unsigned LINE_DEPTH = 2 * MAX_COARSE;
    localparam int unsigned CNT_W      = $clog2(LINE_DEPTH);
    localparam int unsigned SB         = SAMPLE_BITS;

    // Size registers, kept as last fine index
    logic [CNT_W-1:0] r_row_last, r_col_last;
    // Raster position of the next sample
    logic [CNT_W-1:0] r_row_cnt, r_col_cnt, n_row_cnt, n_col_cnt;

    // Line buffer: each entry holds {row r-2, row r-1} for one column
    logic [2*SB-1:0] r_line [LINE_DEPTH];
    logic [2*SB-1:0] r_rd;

    // Stage one: sample waiting for its line buffer data
    logic                 r_s1_valid;
    logic signed [SB-1:0] r_s1_x;
    logic [CNT_W-1:0]     r_s1_c;
    logic                 r_s1_rge1, r_s1_rge2, r_s1_cge1, r_s1_cge2;
    logic                 r_s1_rodd, r_s1_rlast, r_s1_codd, r_s1_clast;

    // Window columns c-2 (0..2) and c-1 (3..5), rows r-2, r-1, r
    logic signed [SB-1:0] r_win [6];

    logic                 accept, s1_emit, s1_go;
    logic                 row_end, col_end;
    logic signed [SB-1:0] cur_col [3];
    logic signed [SB-1:0] prev1 [3];
    logic signed [SB-1:0] prev2 [3];
    logic [NUM_TAPS*SB-1:0] taps;
    t_wflags              flags;

    assign o_cfg_ready = 1'b1;

    // Stage one moves on unless it holds a window and the queue is full
    assign s1_emit    = (r_s1_rodd || r_s1_rlast) && (r_s1_codd || r_s1_clast);
    assign s1_go      = r_s1_valid && !(s1_emit && i_q_full);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign accept     = i_in_valid && !o_in_stall;

    // Advance the raster position
    assign col_end = (r_col_cnt == r_col_last);
    assign row_end = (r_row_cnt == r_row_last);
    always_comb begin
        n_row_cnt = r_row_cnt;
        n_col_cnt = r_col_cnt;
        if (accept) begin
            if (col_end) begin
                n_col_cnt = '0;
                n_row_cnt = row_end ? '0 : r_row_cnt + 1'b1;
            end else begin
                n_col_cnt = r_col_cnt + 1'b1;
            end
        end
    end

    // Config writes and counters; a valid write to either size register restarts the grid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_last <= CNT_W'(fine_last(CFG_W'(2), MAX_COARSE));
            r_col_last <= CNT_W'(fine_last(CFG_W'(2), MAX_COARSE));
            r_row_cnt  <= '0;
            r_col_cnt  <= '0;
        end else if (i_cfg_valid && o_cfg_ready
                     && (i_cfg_index == CFG_COARSE_ROWS || i_cfg_index == CFG_COARSE_COLS)) begin
            if (i_cfg_index == CFG_COARSE_ROWS) begin
                r_row_last <= CNT_W'(fine_last(i_cfg_data, MAX_COARSE));
            end else begin
                r_col_last <= CNT_W'(fine_last(i_cfg_data, MAX_COARSE));
            end
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else begin
            r_row_cnt <= n_row_cnt;
            r_col_cnt <= n_col_cnt;
        end
    end

    // Line buffer: read on accept, write back when stage one moves on
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_line[r_col_cnt];
        end
        if (s1_go) begin
            r_line[r_s1_c] <= {r_rd[SB-1:0], r_s1_x};
        end
    end

    // Stage one valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept || (r_s1_valid && !s1_go);
        end
    end

    // Stage one payload: sample and position classification
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x     <= i_fine_sample;
            r_s1_c     <= r_col_cnt;
            r_s1_rge1  <= (r_row_cnt != '0);
            r_s1_rge2  <= (r_row_cnt[CNT_W-1:1] != '0);
            r_s1_cge1  <= (r_col_cnt != '0);
            r_s1_cge2  <= (r_col_cnt[CNT_W-1:1] != '0);
            r_s1_rodd  <= r_row_cnt[0];
            r_s1_codd  <= r_col_cnt[0];
            r_s1_rlast <= row_end;
            r_s1_clast <= col_end;
        end
    end

    // Build the 3x3 window, masking rows and columns before the grid start
    always_comb begin
        cur_col[0] = r_s1_rge2 ? signed'(r_rd[2*SB-1:SB]) : '0;
        cur_col[1] = r_s1_rge1 ? signed'(r_rd[SB-1:0]) : '0;
        cur_col[2] = r_s1_x;
        for (int k = 0; k < 3; k++) begin
            prev1[k] = r_s1_cge1 ? r_win[3+k] : '0;
            prev2[k] = r_s1_cge2 ? r_win[k] : '0;
        end
        for (int k = 0; k < 3; k++) begin
            taps[k*SB +: SB]       = prev2[k];
            taps[(3+k)*SB +: SB]   = prev1[k];
            taps[(6+k)*SB +: SB]   = cur_col[k];
        end
        flags.row_odd = r_s1_rodd;
        flags.col_odd = r_s1_codd;
        flags.last    = r_s1_rlast && r_s1_clast;
    end

    // Shift the window by one column
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k]   <= prev1[k];
                r_win[3+k] <= cur_col[k];
            end
        end
    end

    // Forward complete windows to the queue
    assign o_push      = s1_go && s1_emit;
    assign o_push_data = {flags, taps};

`ifndef NO_ASSERTIONS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("window pushed into full queue");
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col_cnt <= r_col_last)
        else $error("column counter beyond grid");
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted sample lost before stage one");
`endif

endmodule

>>> design/fwr_queue.sv
// Short queue between the front and back parts of the restriction block.
// Holds complete windows so either side can stall on its own. Depends on fwr_pkg.
module fwr_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output logic             o_empty
);
    import fwr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    // Store pushed windows
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push not counted");
`endif

endmodule

>>> design/fwr_back.sv
// Back part of the restriction block: weights each 3x3 window into one coarse value.
// Column sums in one stage, the total in the output register. Depends on fwr_pkg.
module fwr_back #(
    parameter int unsigned SAMPLE_BITS = fwr_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned QW          = $bits(fwr_pkg::t_wflags)
                                         + fwr_pkg::NUM_TAPS * SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Window queue pop side
    input  logic                                 i_q_empty,
    input  logic [QW-1:0]                        i_pop_data,
    output logic                                 o_pop,
    // Result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [fwr_pkg::OUT_W-1:0]     o_coarse_value,
    output logic                                 o_is_last
);
    import fwr_pkg::*;

    localparam int unsigned SB = SAMPLE_BITS;
    localparam int unsigned CW = SB + 2;   // one column, row weights sum to 4
    localparam int unsigned TW = SB + 4;   // full window, weights sum to 16

    t_wflags              in_flags;
    logic signed [SB-1:0] tap [3][3];
    logic signed [CW-1:0] col_sum [3];

    logic                 r_b1_valid;
    logic signed [CW-1:0] r_col_sum [3];
    logic                 r_b1_col_odd, r_b1_last;

    logic signed [TW-1:0] total;
    logic                 out_en, b1_en;

    // Output register takes a new value when empty or being taken
    assign out_en = !o_out_valid || !i_out_stall;
    assign b1_en  = !r_b1_valid || out_en;
    assign o_pop  = b1_en && !i_q_empty;

    // Unpack the window and weight along the rows
    always_comb begin
        in_flags = t_wflags'(i_pop_data[QW-1 -: $bits(t_wflags)]);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                tap[i][j] = signed'(i_pop_data[(i*3+j)*SB +: SB]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (in_flags.row_odd) begin
                col_sum[i] = CW'(tap[i][0]) + (CW'(tap[i][1]) <<< 1) + CW'(tap[i][2]);
            end else begin
                col_sum[i] = CW'(tap[i][1]) + (CW'(tap[i][2]) <<< 1);
            end
        end
    end

    // Column sum stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (b1_en) begin
            r_b1_valid <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_col_sum    <= col_sum;
            r_b1_col_odd <= in_flags.col_odd;
            r_b1_last    <= in_flags.last;
        end
    end

    // Weight along the columns
    always_comb begin
        if (r_b1_col_odd) begin
            total = TW'(r_col_sum[0]) + (TW'(r_col_sum[1]) <<< 1) + TW'(r_col_sum[2]);
        end else begin
            total = TW'(r_col_sum[1]) + (TW'(r_col_sum[2]) <<< 1);
        end
    end

    // Output register, value kept modulo the output width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_en) begin
            o_out_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_b1_valid) begin
            o_coarse_value <= OUT_W'(total);
            o_is_last      <= r_b1_last;
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_b1_valid)
        else $error("popped window lost");
    a_b1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b1_valid && !out_en) |=> r_b1_valid)
        else $error("column sums dropped while output stalled");
    a_b1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b1_valid && out_en) |=> o_out_valid)
        else $error("column sums not delivered to output");
`endif

endmodule

>>> design/full_weighting_restrict_2d.sv
// Top level of the 2D multigrid full-weighting restriction block.
// Connects fwr_front, fwr_queue and fwr_back. Depends on fwr_pkg.

// The block takes one fine sample per cycle, in raster order with the column fastest,
// over a (2R-1) by (2C-1) grid, and returns the coarse R by C grid as 4*center +
// 2*edges + corners, with outside neighbours as zero. It sustains one sample per
// cycle unless the queue is full: the line buffer is one memory of 2*MAX_COARSE
// entries of two samples each, read when a sample is accepted and written back one
// stage later, so every sample costs one read and one write of that single memory.
// A coarse value passes stage one, the queue, the column sum and output registers;
// the four-entry queue lets samples keep flowing while results are held. Writing
// either size register restarts the grid at fine point (0,0); sizes are saturated to
// [2, MAX_COARSE]. After the last sample the next grid starts at once. The line buffer
// needs no clearing after reset since rows before the grid start are masked.
module full_weighting_restrict_2d #(
    parameter int unsigned MAX_COARSE  = fwr_pkg::MAX_COARSE_DEF,
    parameter int unsigned SAMPLE_BITS = fwr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Fine sample channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]        i_fine_sample,
    // Coarse result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [fwr_pkg::OUT_W-1:0]     o_coarse_value,
    output logic                                 o_is_last,
    // Configuration channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fwr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [fwr_pkg::CFG_W-1:0]            i_cfg_data
);
    import fwr_pkg::*;

    localparam int unsigned QW      = $bits(t_wflags) + NUM_TAPS * SAMPLE_BITS;
    localparam int unsigned Q_DEPTH = 4;

    logic          push, pop, q_full, q_empty;
    logic [QW-1:0] push_data, pop_data;

    fwr_front #(
        .MAX_COARSE  (MAX_COARSE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .QW          (QW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_fine_sample (i_fine_sample),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_push        (push),
        .o_push_data   (push_data),
        .i_q_full      (q_full)
    );

    fwr_queue #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (q_empty)
    );

    fwr_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .QW          (QW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_pop_data     (pop_data),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_coarse_value (o_coarse_value),
        .o_is_last      (o_is_last)
    );

endmodule
